// ===== hdl/lssc_pkg.sv =====
// ----------------------------------------------------------------------------
// Log-sigmoid soft clipper: shared types, constants and curve functions
// Fixed-point constants, pipeline control type and the elaboration-time
// routines that build the curve nodes in Q8.56.
// ----------------------------------------------------------------------------
`default_nettype none

package lssc_pkg;

   localparam int FRAC_BITS = 56;
   localparam int VAL_W     = 56;
   localparam int HALF_W    = 28;
   localparam int MID_W     = 58;
   localparam int LIM_W     = 36;
   localparam int MAG_W     = 31;
   localparam int OUT_W     = 32;
   localparam int DIV_STEPS = 4;
   localparam int X_LIMIT   = 22;
   localparam int EXP_TERMS = 24;
   localparam int LN_TERMS  = 30;

   localparam logic [63:0]      Q_ONE     = 64'd1 << FRAC_BITS;
   localparam logic [LIM_W-1:0] RAW_LIMIT = 36'd47244640234;

   typedef struct packed {
      logic valid;
      logic neg;
      logic sat;
   } ctl_type;

   // floor(a * b / 2^56)
   function automatic logic [63:0] mul_q(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[119:56];
   endfunction

   // floor(a * 2^56 / b) for a < b
   function automatic logic [63:0] div_q(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] q;
      logic [63:0] rem;
      int i;
      q   = '0;
      rem = a;
      if (b == 64'd0 || a >= b) begin
         return 64'd0;
      end
      for (i = 0; i < FRAC_BITS; i++) begin
         rem = rem << 1;
         q   = q << 1;
         if (rem >= b) begin
            rem  = rem - b;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   // integer quotient by shift and subtract
   function automatic logic [63:0] long_div(input logic [63:0] n, input logic [63:0] d);
      logic [64:0] rem;
      logic [63:0] q;
      int i;
      rem = '0;
      q   = '0;
      for (i = 63; i >= 0; i--) begin
         rem = {rem[63:0], n[i]};
         q   = q << 1;
         if (rem >= {1'b0, d}) begin
            rem  = rem - {1'b0, d};
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] exp_neg_frac(input logic [63:0] r);
      logic [63:0] term;
      logic [63:0] sum;
      int k;
      term = Q_ONE;
      sum  = Q_ONE;
      for (k = 1; k <= EXP_TERMS; k++) begin
         term = long_div(mul_q(term, r), 64'(k));
         if ((k & 1) != 0) begin
            sum = (sum >= term) ? sum - term : 64'd0;
         end else begin
            sum = sum + term;
         end
      end
      return sum;
   endfunction

   function automatic logic [63:0] exp_neg(input logic [63:0] x);
      logic [63:0] whole;
      logic [63:0] e1;
      logic [63:0] v;
      int i;
      whole = x >> FRAC_BITS;
      e1    = exp_neg_frac(Q_ONE);
      v     = exp_neg_frac(x & (Q_ONE - 64'd1));
      for (i = 0; i < 64; i++) begin
         if (64'(i) < whole) begin
            v = mul_q(v, e1);
         end
      end
      return v;
   endfunction

   function automatic logic [63:0] ln_one_plus(input logic [63:0] y);
      logic [63:0] z;
      logic [63:0] z2;
      logic [63:0] p;
      logic [63:0] sum;
      int k;
      z   = div_q(y, (Q_ONE << 1) + y);
      z2  = mul_q(z, z);
      p   = z;
      sum = '0;
      for (k = 0; k < LN_TERMS; k++) begin
         sum = sum + long_div(p, 64'(2 * k + 1));
         p   = mul_q(p, z2);
      end
      return sum << 1;
   endfunction

   // curve node k of n equal segments over 0 <= x <= 22
   function automatic logic [63:0] curve_node(input int k, input int n);
      logic [63:0] num;
      logic [63:0] n64;
      logic [63:0] whole;
      logic [63:0] x;
      logic [63:0] l;
      logic [63:0] ln2;
      num   = 64'(X_LIMIT) * 64'(k);
      n64   = 64'(n);
      whole = long_div(num, n64);
      x     = (whole << FRAC_BITS) + div_q(num - whole * n64, n64);
      l     = ln_one_plus(exp_neg(x));
      ln2   = ln_one_plus(Q_ONE);
      return (ln2 >= l) ? ln2 - l : 64'd0;
   endfunction

   // floor(v * (2^31 - 1) / 2^56)
   function automatic logic [MAG_W-1:0] scale_full(input logic [VAL_W-1:0] v);
      logic [VAL_W+MAG_W-1:0] p;
      p = {v, MAG_W'(0)} - {MAG_W'(0), v};
      return p[VAL_W+MAG_W-1:FRAC_BITS];
   endfunction

   localparam logic [63:0]      LN2_Q   = ln_one_plus(Q_ONE);
   localparam logic [VAL_W-1:0] LN2_VAL = LN2_Q[VAL_W-1:0];
   localparam logic [MAG_W-1:0] SAT_MAG = scale_full(LN2_VAL);

endpackage

`default_nettype wire

// ===== hdl/lssc_prep.sv =====
// ----------------------------------------------------------------------------
// Log-sigmoid soft clipper: input conditioning
// Takes the magnitude and sign of the sample, flags saturation and scales
// the magnitude by the segment count to seed the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module lssc_prep
   import lssc_pkg::*;
#(
   parameter int ACC_WIDTH      = 40,
   parameter int CURVE_SEGMENTS = 64,
   localparam int SEG_W         = $clog2(CURVE_SEGMENTS),
   localparam int QUOT_W        = SEG_W + FRAC_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  logic signed [ACC_WIDTH-1:0] in_sample,
   output ctl_type                     out_ctl,
   output logic [LIM_W-1:0]            out_rem,
   output logic [QUOT_W-1:0]           out_quot
);

   localparam int SCALED_W = LIM_W + SEG_W;

   ctl_type              ctl1_ff, ctl1_in;
   logic [ACC_WIDTH-1:0] mag1_ff, mag1_in;
   logic [ACC_WIDTH-1:0] raw;
   ctl_type              ctl2_ff, ctl2_in;
   logic [LIM_W-1:0]     rem2_ff, rem2_in;
   logic [QUOT_W-1:0]    quot2_ff, quot2_in;
   logic [63:0]          mag_wide;
   logic [SCALED_W-1:0]  scaled;

   always_comb begin
      raw      = in_sample;
      ctl1_in  = '{valid: in_valid, neg: raw[ACC_WIDTH-1], sat: 1'b0};
      mag1_in  = raw[ACC_WIDTH-1] ? (~raw) + ACC_WIDTH'(1) : raw;

      mag_wide = 64'(mag1_ff);
      scaled   = SCALED_W'(mag_wide[LIM_W-1:0]) * SCALED_W'(CURVE_SEGMENTS);
      ctl2_in  = ctl1_ff;
      ctl2_in.sat = (mag_wide >= 64'(RAW_LIMIT));
      rem2_in  = scaled[SCALED_W-1:SEG_W];
      quot2_in = {scaled[SEG_W-1:0], FRAC_BITS'(0)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
      end else if (advance) begin
         ctl1_ff  <= ctl1_in;
         mag1_ff  <= mag1_in;
         ctl2_ff  <= ctl2_in;
         rem2_ff  <= rem2_in;
         quot2_ff <= quot2_in;
      end
   end

   assign out_ctl  = ctl2_ff;
   assign out_rem  = rem2_ff;
   assign out_quot = quot2_ff;

endmodule

`default_nettype wire

// ===== hdl/lssc_div.sv =====
// ----------------------------------------------------------------------------
// Log-sigmoid soft clipper: pipelined constant divider
// Restoring division by the raw input limit, a few quotient bits per stage,
// giving segment index and in-segment position in one quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module lssc_div
   import lssc_pkg::*;
#(
   parameter int QUOT_W = 62
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  ctl_type           in_ctl,
   input  logic [LIM_W-1:0]  in_rem,
   input  logic [QUOT_W-1:0] in_quot,
   output ctl_type           out_ctl,
   output logic [QUOT_W-1:0] out_quot
);

   localparam int STAGES = (QUOT_W + DIV_STEPS - 1) / DIV_STEPS;

   ctl_type           ctl_ff  [STAGES];
   logic [LIM_W-1:0]  rem_ff  [STAGES];
   logic [QUOT_W-1:0] quot_ff [STAGES];
   logic [LIM_W-1:0]  rem_in  [STAGES];
   logic [QUOT_W-1:0] quot_in [STAGES];
   wire  ctl_type     ctl_src [STAGES];
   wire  [LIM_W-1:0]  rem_src [STAGES];
   wire  [QUOT_W-1:0] quot_src [STAGES];

   assign ctl_src[0]  = in_ctl;
   assign rem_src[0]  = in_rem;
   assign quot_src[0] = in_quot;

   for (genvar s = 1; s < STAGES; s++) begin : g_link
      assign ctl_src[s]  = ctl_ff[s-1];
      assign rem_src[s]  = rem_ff[s-1];
      assign quot_src[s] = quot_ff[s-1];
   end

   always_comb begin : div_steps
      logic [LIM_W-1:0]  r;
      logic [QUOT_W-1:0] q;
      logic [LIM_W:0]    trial;
      for (int s = 0; s < STAGES; s++) begin
         r     = rem_src[s];
         q     = quot_src[s];
         trial = '0;
         for (int j = 0; j < DIV_STEPS; j++) begin
            if (s * DIV_STEPS + j < QUOT_W) begin
               trial = {r, q[QUOT_W-1]};
               q     = {q[QUOT_W-2:0], 1'b0};
               if (trial >= {1'b0, RAW_LIMIT}) begin
                  r    = LIM_W'(trial - {1'b0, RAW_LIMIT});
                  q[0] = 1'b1;
               end else begin
                  r = trial[LIM_W-1:0];
               end
            end
         end
         rem_in[s]  = r;
         quot_in[s] = q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STAGES; s++) begin
            ctl_ff[s] <= '0;
         end
      end else if (advance) begin
         for (int s = 0; s < STAGES; s++) begin
            ctl_ff[s]  <= ctl_src[s];
            rem_ff[s]  <= rem_in[s];
            quot_ff[s] <= quot_in[s];
         end
      end
   end

   assign out_ctl  = ctl_ff[STAGES-1];
   assign out_quot = quot_ff[STAGES-1];

   a_rem_below_limit: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff[STAGES-1].valid && !ctl_ff[STAGES-1].sat) |-> rem_ff[STAGES-1] < RAW_LIMIT)
      else $error("divider remainder not below limit");

endmodule

`default_nettype wire

// ===== hdl/lssc_interp.sv =====
// ----------------------------------------------------------------------------
// Log-sigmoid soft clipper: curve interpolation and output scaling
// Reads the curve ROM, blends within the segment or takes ln2 when saturated,
// scales back to full scale and restores the sign.
// ----------------------------------------------------------------------------
`default_nettype none

module lssc_interp
   import lssc_pkg::*;
#(
   parameter int CURVE_SEGMENTS = 64,
   localparam int SEG_W         = $clog2(CURVE_SEGMENTS),
   localparam int QUOT_W        = SEG_W + FRAC_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  ctl_type                 in_ctl,
   input  logic [QUOT_W-1:0]       in_quot,
   output logic                    out_valid,
   output logic signed [OUT_W-1:0] out_sample
);

   localparam logic [OUT_W-1:0] SAT_POS = {1'b0, SAT_MAG};
   localparam logic [OUT_W-1:0] SAT_NEG = (~SAT_POS) + OUT_W'(1);

   wire [VAL_W-1:0] lo_tab   [CURVE_SEGMENTS];
   wire [VAL_W-1:0] diff_tab [CURVE_SEGMENTS];

   for (genvar k = 0; k < CURVE_SEGMENTS; k++) begin : g_rom
      localparam logic [63:0] NODE_LO = curve_node(k, CURVE_SEGMENTS);
      localparam logic [63:0] NODE_HI = curve_node(k + 1, CURVE_SEGMENTS);
      assign lo_tab[k]   = NODE_LO[VAL_W-1:0];
      assign diff_tab[k] = (NODE_HI > NODE_LO) ? VAL_W'(NODE_HI - NODE_LO) : '0;
   end

   logic [SEG_W-1:0] seg;
   logic [MID_W-1:0] blend;

   ctl_type          ctl1_ff, ctl2_ff, ctl3_ff, ctl4_ff, ctl5_ff, ctl6_ff;
   logic [VAL_W-1:0] lo1_ff, lo1_in, diff1_ff, diff1_in, frac1_ff, frac1_in;
   logic [VAL_W-1:0] lo2_ff, hh2_ff, hh2_in, hl2_ff, hl2_in;
   logic [VAL_W-1:0] lh2_ff, lh2_in, ll2_ff, ll2_in;
   logic [VAL_W-1:0] lo3_ff, hh3_ff;
   logic [MID_W-1:0] mid3_ff, mid3_in;
   logic [VAL_W-1:0] val4_ff, val4_in;
   logic [MAG_W-1:0] mag5_ff, mag5_in;
   logic [OUT_W-1:0] out6_ff, out6_in;

   always_comb begin
      seg      = in_quot[QUOT_W-1:FRAC_BITS];
      lo1_in   = lo_tab[seg];
      diff1_in = diff_tab[seg];
      frac1_in = in_quot[FRAC_BITS-1:0];

      hh2_in = VAL_W'(diff1_ff[VAL_W-1:HALF_W]) * VAL_W'(frac1_ff[VAL_W-1:HALF_W]);
      hl2_in = VAL_W'(diff1_ff[VAL_W-1:HALF_W]) * VAL_W'(frac1_ff[HALF_W-1:0]);
      lh2_in = VAL_W'(diff1_ff[HALF_W-1:0]) * VAL_W'(frac1_ff[VAL_W-1:HALF_W]);
      ll2_in = VAL_W'(diff1_ff[HALF_W-1:0]) * VAL_W'(frac1_ff[HALF_W-1:0]);

      mid3_in = MID_W'(hl2_ff) + MID_W'(lh2_ff) + MID_W'(ll2_ff[VAL_W-1:HALF_W]);

      blend   = MID_W'(lo3_ff) + MID_W'(hh3_ff) + MID_W'(mid3_ff[MID_W-1:HALF_W]);
      val4_in = ctl3_ff.sat ? LN2_VAL : blend[VAL_W-1:0];

      mag5_in = scale_full(val4_ff);

      out6_in = ctl5_ff.neg ? (~{1'b0, mag5_ff}) + OUT_W'(1) : {1'b0, mag5_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
         ctl5_ff <= '0;
         ctl6_ff <= '0;
      end else if (advance) begin
         ctl1_ff  <= in_ctl;
         lo1_ff   <= lo1_in;
         diff1_ff <= diff1_in;
         frac1_ff <= frac1_in;
         ctl2_ff  <= ctl1_ff;
         lo2_ff   <= lo1_ff;
         hh2_ff   <= hh2_in;
         hl2_ff   <= hl2_in;
         lh2_ff   <= lh2_in;
         ll2_ff   <= ll2_in;
         ctl3_ff  <= ctl2_ff;
         lo3_ff   <= lo2_ff;
         hh3_ff   <= hh2_ff;
         mid3_ff  <= mid3_in;
         ctl4_ff  <= ctl3_ff;
         val4_ff  <= val4_in;
         ctl5_ff  <= ctl4_ff;
         mag5_ff  <= mag5_in;
         ctl6_ff  <= ctl5_ff;
         out6_ff  <= out6_in;
      end
   end

   assign out_valid  = ctl6_ff.valid;
   assign out_sample = out6_ff;

   a_seg_in_range: assert property (@(posedge clock) disable iff (reset)
      (in_ctl.valid && !in_ctl.sat) |->
         ({1'b0, in_quot[QUOT_W-1:FRAC_BITS]} < (SEG_W + 1)'(CURVE_SEGMENTS)))
      else $error("segment index beyond curve table");

   a_sat_level: assert property (@(posedge clock) disable iff (reset)
      (ctl6_ff.valid && ctl6_ff.sat) |-> (out6_ff == SAT_POS || out6_ff == SAT_NEG))
      else $error("saturated beat not at clip level");

   a_out_bound: assert property (@(posedge clock) disable iff (reset)
      ctl6_ff.valid |->
         ($signed(out6_ff) <= $signed(SAT_POS) && $signed(out6_ff) >= $signed(SAT_NEG)))
      else $error("output beyond clip level");

endmodule

`default_nettype wire

// ===== hdl/log_sigmoid_soft_clipper_core.sv =====
// ----------------------------------------------------------------------------
// Log-sigmoid soft clipper core
// Soft-clips a signed mixed accumulator sample to a 32-bit output sample
// with f(x) = ln2 - ln(1 + e^-x), x = |acc| / (2^31 - 1).
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  req_acc_sample [ACC_WIDTH]
//  rsp      out        rsp_valid/rsp_stall  rsp_clipped_sample [32]
//
//  One beat per cycle in, one beat per cycle out unless a valid result is
//  stalled; beats pass the prep registers, then the divider stages
//  resolving four quotient bits each, then the interpolation stages.
//  Synchronous reset clears the control words (valid, neg, sat) only; no clearing pass.
//  A stalled result freezes every stage and raises req_stall in that cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module log_sigmoid_soft_clipper_core
   import lssc_pkg::*;
#(
   parameter int ACC_WIDTH      = 40,
   parameter int CURVE_SEGMENTS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [ACC_WIDTH-1:0] req_acc_sample,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [OUT_W-1:0]     rsp_clipped_sample
);

   localparam int QUOT_W = $clog2(CURVE_SEGMENTS) + FRAC_BITS;

   logic              advance;
   ctl_type           prep_ctl;
   logic [LIM_W-1:0]  prep_rem;
   logic [QUOT_W-1:0] prep_quot;
   ctl_type           div_ctl;
   logic [QUOT_W-1:0] div_quot;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   lssc_prep #(
      .ACC_WIDTH      (ACC_WIDTH),
      .CURVE_SEGMENTS (CURVE_SEGMENTS)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_sample (req_acc_sample),
      .out_ctl   (prep_ctl),
      .out_rem   (prep_rem),
      .out_quot  (prep_quot)
   );

   lssc_div #(
      .QUOT_W (QUOT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_ctl   (prep_ctl),
      .in_rem   (prep_rem),
      .in_quot  (prep_quot),
      .out_ctl  (div_ctl),
      .out_quot (div_quot)
   );

   lssc_interp #(
      .CURVE_SEGMENTS (CURVE_SEGMENTS)
   ) u_interp (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_ctl     (div_ctl),
      .in_quot    (div_quot),
      .out_valid  (rsp_valid),
      .out_sample (rsp_clipped_sample)
   );

endmodule

`default_nettype wire

// ===== tb/tb_log_sigmoid_soft_clipper_core.sv =====
// ----------------------------------------------------------------------------
// Testbench for the log-sigmoid soft clipper core
// Feeds signed accumulator samples through the valid/stall handshake with
// random gaps and stalls. A long receiver hold-off backs the pipeline up.
// Each returned beat is checked against a bit-exact fixed-point curve model
// built from its own Q8.56 node table.
// ----------------------------------------------------------------------------

module tb_log_sigmoid_soft_clipper_core;

   localparam int ACC_W      = 40;
   localparam int CURVE_SEGS = 64;
   localparam int FRAC_Q     = 56;
   localparam int OUT_BITS   = lssc_pkg::OUT_W;

   localparam logic [63:0] ONE_Q   = 64'd1 << FRAC_Q;
   localparam logic [63:0] FULL_Q  = 64'd2147483647;
   localparam logic [63:0] RAW_LIM = 64'd22 * FULL_Q;
   localparam logic [63:0] SEG_LEN = RAW_LIM / 64'(CURVE_SEGS);

   typedef logic signed [ACC_W-1:0]    acc_t;
   typedef logic signed [OUT_BITS-1:0] clip_t;

   class clip_scoreboard;
      logic [63:0] curve_node_q [0:CURVE_SEGS];
      logic [63:0] ln2_level;
      clip_t       pending_clips [$];
      int          errors;

      function new();
         logic [63:0] num;
         logic [63:0] x;
         logic [63:0] l;
         int k;
         errors    = 0;
         ln2_level = ln1p_q(ONE_Q);
         for (k = 0; k <= CURVE_SEGS; k++) begin
            num = 64'(22 * k);
            x   = ((num / 64'(CURVE_SEGS)) << FRAC_Q) +
                  fix_div(num % 64'(CURVE_SEGS), 64'(CURVE_SEGS));
            l   = ln1p_q(exp_neg_q(x));
            curve_node_q[k] = (ln2_level >= l) ? ln2_level - l : 64'd0;
         end
      endfunction

      function logic [63:0] fix_mul(logic [63:0] a, logic [63:0] b);
         logic [127:0] p;
         p = 128'(a) * 128'(b);
         return 64'(p >> FRAC_Q);
      endfunction

      function logic [63:0] fix_div(logic [63:0] a, logic [63:0] b);
         logic [63:0] q;
         logic [63:0] rem;
         int i;
         q   = '0;
         rem = a;
         if (b == 64'd0 || a >= b) begin
            return 64'd0;
         end
         for (i = 0; i < FRAC_Q; i++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= b) begin
               rem  = rem - b;
               q[0] = 1'b1;
            end
         end
         return q;
      endfunction

      function logic [63:0] exp_unit(logic [63:0] r);
         logic [63:0] term;
         logic [63:0] sum;
         int k;
         term = ONE_Q;
         sum  = ONE_Q;
         for (k = 1; k <= 24; k++) begin
            term = fix_mul(term, r) / 64'(k);
            if (k % 2 == 1) begin
               sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
               sum = sum + term;
            end
         end
         return sum;
      endfunction

      function logic [63:0] exp_neg_q(logic [63:0] x);
         logic [63:0] whole;
         logic [63:0] e1;
         logic [63:0] v;
         int i;
         whole = x >> FRAC_Q;
         e1    = exp_unit(ONE_Q);
         v     = exp_unit(x & (ONE_Q - 64'd1));
         for (i = 0; i < 64 && 64'(i) < whole; i++) begin
            v = fix_mul(v, e1);
         end
         return v;
      endfunction

      function logic [63:0] ln1p_q(logic [63:0] y);
         logic [63:0] z;
         logic [63:0] z2;
         logic [63:0] p;
         logic [63:0] sum;
         int k;
         z   = fix_div(y, 2 * ONE_Q + y);
         z2  = fix_mul(z, z);
         p   = z;
         sum = '0;
         for (k = 0; k < 30; k++) begin
            sum = sum + p / 64'(2 * k + 1);
            p   = fix_mul(p, z2);
         end
         return 2 * sum;
      endfunction

      function clip_t soft_clip(acc_t acc);
         logic signed [63:0] wide;
         logic [63:0] a;
         logic [63:0] scaled;
         logic [63:0] seg;
         logic [63:0] t;
         logic [63:0] u;
         logic [63:0] lo;
         logic [63:0] hi;
         logic [63:0] v;
         logic [63:0] mag;
         logic neg;
         wide = acc;
         neg  = acc[ACC_W-1];
         a    = neg ? -wide : wide;
         if (a >= RAW_LIM) begin
            v = ln2_level;
         end else begin
            scaled = a * 64'(CURVE_SEGS);
            seg    = scaled / RAW_LIM;
            if (seg >= 64'(CURVE_SEGS)) begin
               seg = 64'(CURVE_SEGS - 1);
            end
            t  = scaled - seg * RAW_LIM;
            u  = fix_div(t, RAW_LIM);
            lo = curve_node_q[int'(seg)];
            hi = curve_node_q[int'(seg) + 1];
            v  = lo + fix_mul((hi > lo) ? hi - lo : 64'd0, u);
         end
         mag = fix_mul(v, FULL_Q);
         return neg ? clip_t'(64'd0 - mag) : clip_t'(mag);
      endfunction

      function void note_sample(acc_t acc);
         pending_clips.push_back(soft_clip(acc));
      endfunction

      function void check_result(clip_t actual);
         clip_t want;
         if (pending_clips.size() == 0) begin
            $error("clipped_sample: beat with nothing expected, actual %0d", actual);
            errors++;
            return;
         end
         want = pending_clips.pop_front();
         if (want !== actual) begin
            $error("clipped_sample mismatch: expected %0d, actual %0d", want, actual);
            errors++;
         end
      endfunction

      function int pending();
         return pending_clips.size();
      endfunction

      function bit finish_ok();
         if (pending_clips.size() != 0) begin
            $error("clipped_sample: %0d beats never arrived", pending_clips.size());
            errors++;
         end
         return errors == 0;
      endfunction
   endclass

   logic  clock          = 1'b0;
   logic  reset          = 1'b1;
   logic  req_valid      = 1'b0;
   logic  req_stall;
   acc_t  req_acc_sample = '0;
   logic  rsp_valid;
   logic  rsp_stall      = 1'b0;
   clip_t rsp_clipped_sample;

   clip_scoreboard clip_sb = new();

   log_sigmoid_soft_clipper_core #(
      .ACC_WIDTH      (ACC_W),
      .CURVE_SEGMENTS (CURVE_SEGS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_acc_sample     (req_acc_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_clipped_sample (rsp_clipped_sample)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         clip_sb.check_result(rsp_clipped_sample);
      end
   end

   // called at a falling edge; returns at the falling edge after the beat
   task automatic send_sample(input acc_t s, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_acc_sample <= s;
      do begin
         @(posedge clock);
      end while (req_stall);
      clip_sb.note_sample(s);
      @(negedge clock);
   endtask

   function automatic acc_t draw_sample();
      logic [63:0] r;
      logic signed [63:0] m;
      int sel;
      sel = $urandom_range(0, 99);
      r   = {$urandom, $urandom};
      if (sel < 55) begin
         m = r % RAW_LIM;
      end else if (sel < 70) begin
         m = r >> $urandom_range(4, 63);
      end else if (sel < 82) begin
         m = SEG_LEN * 64'($urandom_range(0, CURVE_SEGS)) + $urandom_range(0, 8) - 4;
         if (m < 0) begin
            m = 0;
         end
      end else begin
         return acc_t'(r);
      end
      return $urandom_range(0, 1) ? acc_t'(-m) : acc_t'(m);
   endfunction

   initial begin : rsp_side
      int beats;
      int hold;
      beats = 0;
      @(negedge clock);
      forever begin
         if (beats == 300 || beats == 800) begin
            rsp_stall <= 1'b1;
            repeat (400) @(negedge clock);
         end
         hold = ((beats / 64) % 3 == 1) ? 0 : $urandom_range(0, 15);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do begin
            @(posedge clock);
         end while (!rsp_valid || reset);
         beats++;
         @(negedge clock);
      end
   end

   initial begin : req_side
      acc_t corner_q [$];
      int i;
      int waited;
      corner_q = '{
         acc_t'(0), acc_t'(1), acc_t'(-1),
         {1'b0, {(ACC_W-1){1'b1}}}, {1'b1, {(ACC_W-1){1'b0}}},
         acc_t'(FULL_Q), acc_t'(64'd0 - FULL_Q),
         acc_t'(RAW_LIM - 64'd1), acc_t'(RAW_LIM), acc_t'(RAW_LIM + 64'd1),
         acc_t'(64'd1 - RAW_LIM), acc_t'(64'd0 - RAW_LIM),
         acc_t'(SEG_LEN - 64'd1), acc_t'(SEG_LEN), acc_t'(2 * SEG_LEN),
         acc_t'(64'd0 - SEG_LEN), acc_t'(32 * SEG_LEN), acc_t'(63 * SEG_LEN),
         acc_t'(64'd1 << 31), acc_t'(64'd0 - (64'd1 << 31)),
         acc_t'(64'd1 << 35), acc_t'(64'd0 - (64'd1 << 35)),
         acc_t'(40'h55_5555_5555), acc_t'(40'hAA_AAAA_AAAA)
      };
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (corner_q[k]) begin
         send_sample(corner_q[k], $urandom_range(0, 3));
      end
      for (i = 0; i < 1050; i++) begin
         send_sample(draw_sample(), ((i / 60) % 3 == 0) ? 0 : $urandom_range(0, 15));
      end
      req_valid <= 1'b0;

      waited = 0;
      while (clip_sb.pending() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
      if (clip_sb.finish_ok()) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
